/* src/srfr_pkg.sv */
`timescale 1ns / 1ps
package srfr_pkg;

  // Packet slots per file and the widest ACK round.
  localparam int unsigned PacketsPerFile = 32;
  localparam int unsigned MaxWindow      = 16;

  // Configuration register indexes.
  localparam logic RegWindowSize = 1'b0;
  localparam logic RegFileCount  = 1'b1;

  localparam logic FuncPacket  = 1'b0;
  localparam logic FuncTimeout = 1'b1;

  typedef struct packed {
    logic       func;
    logic [9:0] file_index;
    logic [5:0] packet_index;
    logic [5:0] packet_total;
    logic       checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  ack_file;
    logic        all_done;
    logic [31:0] received_map;
    logic        round_last;
  } out_item_t;

  // One file's table entry as held in memory.
  typedef struct packed {
    logic        done;
    logic        known;
    logic [5:0]  count;
    logic [31:0] bitmap;
  } entry_t;

  typedef struct packed {
    logic [4:0]  window_size;
    logic [10:0] file_count;
  } cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PKT,
    S_SCAN,
    S_SCAN_CHK,
    S_EMIT,
    S_EMIT_CHK,
    S_EMIT_PUT,
    S_FLUSH,
    S_FIN
  } state_t;

  // Mask with the low count bits set; count never exceeds PacketsPerFile.
  function automatic logic [31:0] full_mask(input logic [5:0] count);
    logic [32:0] m;
    m = (33'd1 << count) - 33'd1;
    return m[31:0];
  endfunction

endpackage

/* src/srfr_ram.sv */
`timescale 1ns / 1ps
module srfr_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/srfr_cfg.sv */
`timescale 1ns / 1ps
module srfr_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output srfr_pkg::cfg_t cfg
);

  srfr_pkg::cfg_t cfg_r, cfg_nxt;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register write decode on the access phase.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (paddr[2])
        srfr_pkg::RegWindowSize: cfg_nxt.window_size = pwdata[4:0];
        srfr_pkg::RegFileCount:  cfg_nxt.file_count  = pwdata[10:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size <= 5'd8;
      cfg_r.file_count  <= 11'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (paddr[2])
      srfr_pkg::RegWindowSize: prdata = {27'd0, cfg_r.window_size};
      srfr_pkg::RegFileCount:  prdata = {21'd0, cfg_r.file_count};
      default: prdata = 32'd0;
    endcase
  end

endmodule

/* src/selective_repeat_file_receiver.sv */
`timescale 1ns / 1ps
// Selective-repeat file receiver. Per-file state (bitmap, packet count, saved
// mark) lives in one single-port-read RAM of MAX_FILES entries. After reset a
// clearing pass writes every entry, with in_ready low. A packet item is a RAM
// read, then a modify and write back. When a burst ends, the block first walks
// from the window start past saved files, then reads each file of the window
// and emits one bitmap ACK per unsaved file, the last one flagged round_last.
// If the walk passes the last file, a finish ACK (all_done) goes out instead;
// every later item gets one too. out_ready stalls hold the ACK output.
module selective_repeat_file_receiver #(
  parameter int unsigned MAX_FILES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srfr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srfr_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int unsigned AW = $clog2(MAX_FILES);
  localparam int unsigned NW = ($clog2(MAX_FILES + 1) > 11) ? $clog2(MAX_FILES + 1) : 11;
  localparam int unsigned EW = $bits(srfr_pkg::entry_t);

  srfr_pkg::cfg_t cfg;

  srfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // File table memory.
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  srfr_pkg::entry_t wentry, rentry;
  logic [EW-1:0]   rword;

  srfr_ram #(.WIDTH(EW), .DEPTH(MAX_FILES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rword)
  );
  assign rentry = srfr_pkg::entry_t'(rword);

  // Control and working registers.
  srfr_pkg::state_t    state_r, state_nxt;
  logic [NW-1:0]       ptr_r, ptr_nxt;
  logic [NW-1:0]       start_r, start_nxt;
  logic [NW-1:0]       end_r, end_nxt;
  logic                burst_r, burst_nxt;
  logic                fin_r, fin_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [9:0]          pend_file_r, pend_file_nxt;
  logic [31:0]         pend_map_r, pend_map_nxt;
  srfr_pkg::entry_t    cand_r, cand_nxt;
  srfr_pkg::in_item_t  item_r, item_nxt;
  logic                out_valid_r, out_valid_nxt;
  srfr_pkg::out_item_t out_r, out_nxt;

  // Effective limits from configuration.
  logic [NW-1:0] files;
  logic [NW-1:0] fc_ext;
  logic [NW:0]   win_end;
  logic [4:0]    ws;
  logic          slot_free;

  assign fc_ext    = NW'(cfg.file_count);
  assign files     = (fc_ext > NW'(MAX_FILES)) ? NW'(MAX_FILES) : fc_ext;
  assign ws        = (cfg.window_size == 5'd0) ? 5'd1 :
                     (cfg.window_size > 5'(srfr_pkg::MaxWindow)) ?
                     5'(srfr_pkg::MaxWindow) : cfg.window_size;
  assign win_end   = {1'b0, ptr_r} + (NW + 1)'(ws);
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == srfr_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Packet update terms from the entry read for the held item.
  logic [5:0]  tot_sat, cnt;
  logic [31:0] new_map;
  logic [NW-1:0] f_ext;

  assign tot_sat = (item_r.packet_total > 6'(srfr_pkg::PacketsPerFile)) ?
                   6'(srfr_pkg::PacketsPerFile) : item_r.packet_total;
  assign cnt     = rentry.known ? rentry.count : tot_sat;
  assign new_map = rentry.bitmap | (32'd1 << item_r.packet_index[4:0]);
  assign f_ext   = NW'(in_data.file_index);

  // Next state and datapath.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    burst_nxt     = burst_r;
    fin_nxt       = fin_r;
    pend_v_nxt    = pend_v_r;
    pend_file_nxt = pend_file_r;
    pend_map_nxt  = pend_map_r;
    cand_nxt      = cand_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = ptr_r[AW-1:0];
    wentry        = '0;
    raddr         = ptr_r[AW-1:0];

    case (state_r)
      srfr_pkg::S_CLEAR: begin
        we      = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == NW'(MAX_FILES - 1)) begin
          ptr_nxt   = '0;
          state_nxt = srfr_pkg::S_IDLE;
        end
      end

      srfr_pkg::S_IDLE: begin
        raddr = f_ext[AW-1:0];
        if (in_valid) begin
          item_nxt = in_data;
          if (fin_r) begin
            state_nxt = srfr_pkg::S_FIN;
          end else if (in_data.func == srfr_pkg::FuncTimeout) begin
            if (burst_r) begin
              burst_nxt = 1'b0;
              ptr_nxt   = start_r;
              state_nxt = srfr_pkg::S_SCAN;
            end
          end else if (!in_data.checksum_ok || f_ext >= files) begin
            burst_nxt = 1'b0;
            ptr_nxt   = start_r;
            state_nxt = srfr_pkg::S_SCAN;
          end else begin
            state_nxt = srfr_pkg::S_PKT;
          end
        end
      end

      // Read-modify-write of the packet's file entry.
      srfr_pkg::S_PKT: begin
        we           = 1'b1;
        waddr        = AW'(item_r.file_index);
        wentry       = rentry;
        wentry.known = 1'b1;
        wentry.count = cnt;
        ptr_nxt      = start_r;
        state_nxt    = srfr_pkg::S_SCAN;
        burst_nxt    = 1'b0;
        if (!rentry.done && cnt != 6'd0 && item_r.packet_index < cnt) begin
          if (new_map == srfr_pkg::full_mask(cnt)) begin
            wentry.done   = 1'b1;
            wentry.bitmap = '0;
          end else begin
            wentry.bitmap = new_map;
            burst_nxt     = 1'b1;
            state_nxt     = srfr_pkg::S_IDLE;
          end
        end
      end

      // Walk past saved files to the new window start.
      srfr_pkg::S_SCAN: begin
        if (ptr_r >= files) begin
          start_nxt = ptr_r;
          state_nxt = srfr_pkg::S_FIN;
        end else begin
          state_nxt = srfr_pkg::S_SCAN_CHK;
        end
      end

      srfr_pkg::S_SCAN_CHK: begin
        if (rentry.done) begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = srfr_pkg::S_SCAN;
        end else begin
          start_nxt  = ptr_r;
          end_nxt    = (win_end > (NW + 1)'(files)) ? files : win_end[NW-1:0];
          pend_v_nxt = 1'b0;
          state_nxt  = srfr_pkg::S_EMIT;
        end
      end

      srfr_pkg::S_EMIT: begin
        state_nxt = (ptr_r < end_r) ? srfr_pkg::S_EMIT_CHK : srfr_pkg::S_FLUSH;
      end

      srfr_pkg::S_EMIT_CHK: begin
        cand_nxt  = rentry;
        state_nxt = srfr_pkg::S_EMIT_PUT;
      end

      // Hold one ACK back so the round's last one can be flagged.
      srfr_pkg::S_EMIT_PUT: begin
        if (cand_r.done) begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = srfr_pkg::S_EMIT;
        end else if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{ack_file: pend_file_r, all_done: 1'b0,
                              received_map: pend_map_r, round_last: 1'b0};
          end
          pend_v_nxt    = 1'b1;
          pend_file_nxt = ptr_r[9:0];
          pend_map_nxt  = cand_r.bitmap & srfr_pkg::full_mask(cand_r.count);
          ptr_nxt       = ptr_r + 1'b1;
          state_nxt     = srfr_pkg::S_EMIT;
        end
      end

      srfr_pkg::S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{ack_file: pend_file_r, all_done: 1'b0,
                            received_map: pend_map_r, round_last: 1'b1};
          pend_v_nxt    = 1'b0;
          state_nxt     = srfr_pkg::S_IDLE;
        end
      end

      srfr_pkg::S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{ack_file: 10'd0, all_done: 1'b1,
                            received_map: 32'd0, round_last: 1'b1};
          fin_nxt       = 1'b1;
          state_nxt     = srfr_pkg::S_IDLE;
        end
      end

      default: state_nxt = srfr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srfr_pkg::S_CLEAR;
      ptr_r       <= '0;
      start_r     <= '0;
      burst_r     <= 1'b0;
      fin_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      start_r     <= start_nxt;
      burst_r     <= burst_nxt;
      fin_r       <= fin_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    end_r       <= end_nxt;
    pend_file_r <= pend_file_nxt;
    pend_map_r  <= pend_map_nxt;
    cand_r      <= cand_nxt;
    item_r      <= item_nxt;
    out_r       <= out_nxt;
  end

endmodule
